/* rtl/erm_pkg.sv */
`timescale 1ns / 1ps
package erm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int NUM_W = $clog2(TABLE_ENTRIES + 3);
    localparam int ADDR_W = IDX_W + 1;
    localparam int FUNC_W = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int ENT_W = 4 * DATA_W;

    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_ERASE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVF = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] obj;
        logic [DATA_W-1:0] ooff;
        logic [DATA_W-1:0] size;
    } t_ext;

    typedef enum logic [2:0] {
        W_RAM, W_P, W_PMOD, W_NEW, W_TAIL, W_TRIM, W_E
    } t_wsel;

    typedef enum logic [2:0] {
        RS_NONE, RS_OVF, RS_MISS, RS_LOOK, RS_ERASE, RS_UPD
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RDA, S_EVA, S_AEND, S_BP, S_BN, S_BT,
        S_C, S_CW, S_D, S_DW, S_UFIN, S_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic rd;
        logic ld_p;
        logic ld_e;
        logic kill_e;
        logic wr;
        logic hit;
        logic out_load;
        t_wsel wsel;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic ovf;
        logic at_end;
        logic lt_off;
        logic eq_off;
        logic found;
        logic pv;
        logic ev;
        logic tail;
        logic e_skip;
        logic e_lt;
        logic e_eq;
        logic out_busy;
    } t_stat;

endpackage

/* rtl/erm_ram.sv */
`timescale 1ns / 1ps
module erm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/erm_ctrl.sv */
`timescale 1ns / 1ps
module erm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  erm_pkg::t_stat i_stat,
    output erm_pkg::t_cmd  o_cmd
);

    erm_pkg::t_state r_state, n_state;
    erm_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= erm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd = '0;
        cmd.wsel = erm_pkg::W_RAM;
        cmd.res = erm_pkg::RS_NONE;
        unique case (r_state)
            erm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    cmd.clr = 1'b1;
                    n_state = erm_pkg::S_START;
                end
            end
            erm_pkg::S_START: begin
                if (i_stat.func == erm_pkg::FN_UPDATE && i_stat.ovf) begin
                    cmd.res = erm_pkg::RS_OVF;
                    n_state = erm_pkg::S_DONE;
                end else if (i_stat.func == erm_pkg::FN_NONE) begin
                    cmd.res = erm_pkg::RS_MISS;
                    n_state = erm_pkg::S_DONE;
                end else begin
                    n_state = erm_pkg::S_RDA;
                end
            end
            erm_pkg::S_RDA: begin
                if (i_stat.at_end) begin
                    n_state = erm_pkg::S_AEND;
                end else begin
                    cmd.rd = 1'b1;
                    n_state = erm_pkg::S_EVA;
                end
            end
            erm_pkg::S_EVA: begin
                n_state = erm_pkg::S_RDA;
                if (i_stat.func == erm_pkg::FN_ERASE) begin
                    if (!i_stat.found && i_stat.eq_off) begin
                        cmd.hit = 1'b1;
                    end else begin
                        cmd.wr = 1'b1;
                        cmd.wsel = erm_pkg::W_RAM;
                    end
                end else if (i_stat.lt_off) begin
                    cmd.ld_p = 1'b1;
                    if (i_stat.func == erm_pkg::FN_UPDATE && i_stat.pv) begin
                        cmd.wr = 1'b1;
                        cmd.wsel = erm_pkg::W_P;
                    end
                end else begin
                    cmd.ld_e = 1'b1;
                    n_state = erm_pkg::S_AEND;
                end
            end
            erm_pkg::S_AEND: begin
                if (i_stat.func == erm_pkg::FN_UPDATE) begin
                    n_state = erm_pkg::S_BP;
                end else begin
                    cmd.res = (i_stat.func == erm_pkg::FN_ERASE) ? erm_pkg::RS_ERASE
                                                                  : erm_pkg::RS_LOOK;
                    n_state = erm_pkg::S_DONE;
                end
            end
            erm_pkg::S_BP: begin
                if (i_stat.pv) begin
                    cmd.wr = 1'b1;
                    cmd.wsel = erm_pkg::W_PMOD;
                end
                n_state = erm_pkg::S_BN;
            end
            erm_pkg::S_BN: begin
                cmd.wr = 1'b1;
                cmd.wsel = erm_pkg::W_NEW;
                n_state = i_stat.tail ? erm_pkg::S_BT : erm_pkg::S_C;
            end
            erm_pkg::S_BT: begin
                cmd.wr = 1'b1;
                cmd.wsel = erm_pkg::W_TAIL;
                n_state = erm_pkg::S_C;
            end
            erm_pkg::S_C: begin
                if (i_stat.ev) begin
                    if (i_stat.e_skip) begin
                        cmd.kill_e = 1'b1;
                    end else if (i_stat.e_lt) begin
                        cmd.wr = 1'b1;
                        cmd.wsel = erm_pkg::W_TRIM;
                        cmd.kill_e = 1'b1;
                        n_state = erm_pkg::S_D;
                    end else if (i_stat.e_eq) begin
                        cmd.kill_e = 1'b1;
                        n_state = erm_pkg::S_D;
                    end else begin
                        n_state = erm_pkg::S_D;
                    end
                end else if (i_stat.at_end) begin
                    n_state = erm_pkg::S_UFIN;
                end else begin
                    cmd.rd = 1'b1;
                    n_state = erm_pkg::S_CW;
                end
            end
            erm_pkg::S_CW: begin
                cmd.ld_e = 1'b1;
                n_state = erm_pkg::S_C;
            end
            erm_pkg::S_D: begin
                if (i_stat.ev) begin
                    cmd.wr = 1'b1;
                    cmd.wsel = erm_pkg::W_E;
                    cmd.kill_e = 1'b1;
                end else if (i_stat.at_end) begin
                    n_state = erm_pkg::S_UFIN;
                end else begin
                    cmd.rd = 1'b1;
                    n_state = erm_pkg::S_DW;
                end
            end
            erm_pkg::S_DW: begin
                cmd.ld_e = 1'b1;
                n_state = erm_pkg::S_D;
            end
            erm_pkg::S_UFIN: begin
                cmd.res = erm_pkg::RS_UPD;
                n_state = erm_pkg::S_DONE;
            end
            erm_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    n_state = erm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = erm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;
    assign o_in_stall = (r_state != erm_pkg::S_IDLE);

endmodule

/* rtl/erm_dp.sv */
`timescale 1ns / 1ps
module erm_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [erm_pkg::FUNC_W-1:0]   i_func,
    input  logic [erm_pkg::DATA_W-1:0]   i_file_pos,
    input  logic [erm_pkg::DATA_W-1:0]   i_object_number,
    input  logic [erm_pkg::DATA_W-1:0]   i_object_offset,
    input  logic [erm_pkg::DATA_W-1:0]   i_extent_length,
    input  logic                         i_out_stall,
    input  erm_pkg::t_cmd                i_cmd,
    output erm_pkg::t_stat               o_stat,
    output logic                         o_ram_we,
    output logic [erm_pkg::ADDR_W-1:0]   o_ram_waddr,
    output logic [erm_pkg::ENT_W-1:0]    o_ram_wdata,
    output logic [erm_pkg::ADDR_W-1:0]   o_ram_raddr,
    input  logic [erm_pkg::ENT_W-1:0]    i_ram_rdata,
    output logic                         o_out_valid,
    output logic [erm_pkg::STAT_W-1:0]   o_status,
    output logic                         o_covers_offset,
    output logic [erm_pkg::DATA_W-1:0]   o_hit_base,
    output logic [erm_pkg::DATA_W-1:0]   o_hit_object,
    output logic [erm_pkg::DATA_W-1:0]   o_hit_object_offset,
    output logic [erm_pkg::DATA_W-1:0]   o_hit_length,
    output logic [erm_pkg::CNT_W-1:0]    o_entries_used
);

    logic [erm_pkg::FUNC_W-1:0] r_func;
    logic [erm_pkg::DATA_W-1:0] r_off, r_obj, r_ooff, r_len;
    erm_pkg::t_ext r_p, r_e, r_res;
    logic r_pv, r_ev, r_found, r_bank, r_cov, r_out_valid;
    logic [erm_pkg::STAT_W-1:0] r_st;
    logic [erm_pkg::CNT_W-1:0] r_ri, r_cnt;
    logic [erm_pkg::NUM_W-1:0] r_n;
    erm_pkg::t_ext r_o;
    logic [erm_pkg::STAT_W-1:0] r_o_st;
    logic r_o_cov;
    logic [erm_pkg::CNT_W-1:0] r_o_cnt;

    erm_pkg::t_ext rd_ext, pmod, tail_ext, trim_ext, new_ext, wdata;
    logic [erm_pkg::DATA_W:0] stop, p_end, e_end;
    logic [erm_pkg::DATA_W-1:0] d_tail, d_trim;

    assign rd_ext = erm_pkg::t_ext'(i_ram_rdata);
    assign stop = {1'b0, r_off} + {1'b0, r_len};
    assign p_end = {1'b0, r_p.base} + {1'b0, r_p.size};
    assign e_end = {1'b0, r_e.base} + {1'b0, r_e.size};
    assign d_tail = stop[erm_pkg::DATA_W-1:0] - r_p.base;
    assign d_trim = stop[erm_pkg::DATA_W-1:0] - r_e.base;

    always_comb begin
        pmod = r_p;
        if (p_end > {1'b0, r_off}) begin
            pmod.size = r_off - r_p.base;
        end
        tail_ext.base = stop[erm_pkg::DATA_W-1:0];
        tail_ext.obj = r_p.obj;
        tail_ext.ooff = r_p.ooff + d_tail;
        tail_ext.size = p_end[erm_pkg::DATA_W-1:0] - stop[erm_pkg::DATA_W-1:0];
        trim_ext.base = stop[erm_pkg::DATA_W-1:0];
        trim_ext.obj = r_e.obj;
        trim_ext.ooff = r_e.ooff + d_trim;
        trim_ext.size = r_e.size - d_trim;
        new_ext.base = r_off;
        new_ext.obj = r_obj;
        new_ext.ooff = r_ooff;
        new_ext.size = r_len;
        unique case (i_cmd.wsel)
            erm_pkg::W_RAM:  wdata = rd_ext;
            erm_pkg::W_P:    wdata = r_p;
            erm_pkg::W_PMOD: wdata = pmod;
            erm_pkg::W_NEW:  wdata = new_ext;
            erm_pkg::W_TAIL: wdata = tail_ext;
            erm_pkg::W_TRIM: wdata = trim_ext;
            erm_pkg::W_E:    wdata = r_e;
            default:         wdata = r_e;
        endcase
    end

    always_comb begin
        o_stat.func = r_func;
        o_stat.ovf = stop[erm_pkg::DATA_W] && (stop[erm_pkg::DATA_W-1:0] != '0);
        o_stat.at_end = (r_ri == r_cnt);
        o_stat.lt_off = (rd_ext.base < r_off);
        o_stat.eq_off = (rd_ext.base == r_off);
        o_stat.found = r_found;
        o_stat.pv = r_pv;
        o_stat.ev = r_ev;
        o_stat.tail = r_pv && (p_end > stop) && (r_len != '0);
        o_stat.e_skip = (e_end <= stop);
        o_stat.e_lt = ({1'b0, r_e.base} < stop);
        o_stat.e_eq = (r_e.base == r_off);
        o_stat.out_busy = r_out_valid && i_out_stall;
    end

    assign o_ram_we = i_cmd.wr && (r_n < erm_pkg::NUM_W'(erm_pkg::TABLE_ENTRIES));
    assign o_ram_waddr = {~r_bank, r_n[erm_pkg::IDX_W-1:0]};
    assign o_ram_wdata = wdata;
    assign o_ram_raddr = {r_bank, r_ri[erm_pkg::IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_func <= i_func;
            r_off <= i_file_pos;
            r_obj <= i_object_number;
            r_ooff <= i_object_offset;
            r_len <= i_extent_length;
            r_ri <= '0;
            r_n <= '0;
        end else begin
            if (i_cmd.rd) begin
                r_ri <= r_ri + erm_pkg::CNT_W'(1);
            end
            if (i_cmd.wr) begin
                r_n <= r_n + erm_pkg::NUM_W'(1);
            end
        end
        if (i_cmd.ld_p) begin
            r_p <= rd_ext;
        end
        if (i_cmd.ld_e) begin
            r_e <= rd_ext;
        end
        if (i_cmd.hit) begin
            r_res <= rd_ext;
        end
        unique case (i_cmd.res)
            erm_pkg::RS_NONE: begin
            end
            erm_pkg::RS_OVF: begin
                r_st <= erm_pkg::ST_OVF;
                r_cov <= 1'b0;
                r_res <= '0;
            end
            erm_pkg::RS_MISS: begin
                r_st <= erm_pkg::ST_MISS;
                r_cov <= 1'b0;
                r_res <= '0;
            end
            erm_pkg::RS_LOOK: begin
                priority if (r_ev && r_e.base == r_off) begin
                    r_st <= erm_pkg::ST_OK;
                    r_cov <= 1'b1;
                    r_res <= r_e;
                end else if (r_pv && {1'b0, r_off} < p_end) begin
                    r_st <= erm_pkg::ST_OK;
                    r_cov <= 1'b1;
                    r_res <= r_p;
                end else if (r_ev) begin
                    r_st <= erm_pkg::ST_OK;
                    r_cov <= 1'b0;
                    r_res <= r_e;
                end else begin
                    r_st <= erm_pkg::ST_MISS;
                    r_cov <= 1'b0;
                    r_res <= '0;
                end
            end
            erm_pkg::RS_ERASE: begin
                r_cov <= 1'b0;
                if (r_found) begin
                    r_st <= erm_pkg::ST_OK;
                end else begin
                    r_st <= erm_pkg::ST_MISS;
                    r_res <= '0;
                end
            end
            erm_pkg::RS_UPD: begin
                r_cov <= 1'b0;
                if (r_n > erm_pkg::NUM_W'(erm_pkg::TABLE_ENTRIES)) begin
                    r_st <= erm_pkg::ST_FULL;
                    r_res <= '0;
                end else begin
                    r_st <= erm_pkg::ST_OK;
                    r_res <= new_ext;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_o <= r_res;
            r_o_st <= r_st;
            r_o_cov <= r_cov;
            r_o_cnt <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ev <= 1'b0;
            r_found <= 1'b0;
            r_bank <= 1'b0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_pv <= 1'b0;
                r_ev <= 1'b0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.ld_p) begin
                    r_pv <= 1'b1;
                end
                if (i_cmd.ld_e) begin
                    r_ev <= 1'b1;
                end else if (i_cmd.kill_e) begin
                    r_ev <= 1'b0;
                end
                if (i_cmd.hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.res == erm_pkg::RS_ERASE && r_found) begin
                r_bank <= ~r_bank;
                r_cnt <= r_cnt - erm_pkg::CNT_W'(1);
            end
            if (i_cmd.res == erm_pkg::RS_UPD
                    && r_n <= erm_pkg::NUM_W'(erm_pkg::TABLE_ENTRIES)) begin
                r_bank <= ~r_bank;
                r_cnt <= r_n[erm_pkg::CNT_W-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_o_st;
    assign o_covers_offset = r_o_cov;
    assign o_hit_base = r_o.base;
    assign o_hit_object = r_o.obj;
    assign o_hit_object_offset = r_o.ooff;
    assign o_hit_length = r_o.size;
    assign o_entries_used = r_o_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= erm_pkg::CNT_W'(erm_pkg::TABLE_ENTRIES))
        else $error("entry count past table size");

    a_rd_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_ri < r_cnt))
        else $error("read beyond held extents");

    a_cnt_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$stable(r_cnt) && $past(i_rst_n))
            |-> $past(i_cmd.res == erm_pkg::RS_ERASE || i_cmd.res == erm_pkg::RS_UPD))
        else $error("entry count changed outside commit");

endmodule

/* rtl/extent_range_map.sv */
`timescale 1ns / 1ps
// sorted extent table of up to TABLE_ENTRIES entries held in a double-buffered
// ram (two banks of TABLE_ENTRIES); update and erase stream the live bank into
// the other one and flip banks on success, so a failed update leaves the table
// as it was. the single ram read port has a registered read. lookup stops at the
// first extent at or above the offset and erase walks the whole table. one item
// is in work at a time; the result register lets the next item in while a result
// waits. no clearing pass after reset.
module extent_range_map (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [erm_pkg::FUNC_W-1:0] i_func,
    input  logic [erm_pkg::DATA_W-1:0] i_file_pos,
    input  logic [erm_pkg::DATA_W-1:0] i_object_number,
    input  logic [erm_pkg::DATA_W-1:0] i_object_offset,
    input  logic [erm_pkg::DATA_W-1:0] i_extent_length,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [erm_pkg::STAT_W-1:0] o_status,
    output logic                       o_covers_offset,
    output logic [erm_pkg::DATA_W-1:0] o_hit_base,
    output logic [erm_pkg::DATA_W-1:0] o_hit_object,
    output logic [erm_pkg::DATA_W-1:0] o_hit_object_offset,
    output logic [erm_pkg::DATA_W-1:0] o_hit_length,
    output logic [erm_pkg::CNT_W-1:0]  o_entries_used
);

    erm_pkg::t_cmd cmd;
    erm_pkg::t_stat stat;
    logic ram_we;
    logic [erm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [erm_pkg::ENT_W-1:0] ram_wdata, ram_rdata;

    erm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    erm_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_func              (i_func),
        .i_file_pos          (i_file_pos),
        .i_object_number     (i_object_number),
        .i_object_offset     (i_object_offset),
        .i_extent_length     (i_extent_length),
        .i_out_stall         (i_out_stall),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_ram_we            (ram_we),
        .o_ram_waddr         (ram_waddr),
        .o_ram_wdata         (ram_wdata),
        .o_ram_raddr         (ram_raddr),
        .i_ram_rdata         (ram_rdata),
        .o_out_valid         (o_out_valid),
        .o_status            (o_status),
        .o_covers_offset     (o_covers_offset),
        .o_hit_base          (o_hit_base),
        .o_hit_object        (o_hit_object),
        .o_hit_object_offset (o_hit_object_offset),
        .o_hit_length        (o_hit_length),
        .o_entries_used      (o_entries_used)
    );

    erm_ram #(
        .WIDTH (erm_pkg::ENT_W),
        .DEPTH (2 * erm_pkg::TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
